// File: src/mbfs_pkg.sv
// ----------------------------------------------------------------------------
// mbfs_pkg
// Shared types and constants of the masked bilinear field sampler.
// ----------------------------------------------------------------------------
package mbfs_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_QUERY     = 2'd0,
        OP_LOAD_ZONE = 2'd1,
        OP_LOAD_CELL = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    // Stream widths
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 40;

    // Cell word: {valid, u, v}
    localparam int CELL_W = 37;

    // Grid position divider: Q.16 quotient below 255*65536, divisor up to 2^25
    localparam int DIV_QW = 24;
    localparam int DIV_DW = 26;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ZONE,
        ST_AREA,
        ST_NUMX,
        ST_LIMX,
        ST_CHKX,
        ST_WAITX,
        ST_NUMY,
        ST_LIMY,
        ST_CHKY,
        ST_WAITY,
        ST_ROW0,
        ST_ROW1,
        ST_RADDR,
        ST_RDATA,
        ST_WGT,
        ST_ACC,
        ST_EMIT
    } state_t;

endpackage

// File: src/masked_bilinear_field_sampler_core.sv
// ----------------------------------------------------------------------------
// masked_bilinear_field_sampler_core
// Bilinear sampling of up to NUM_ZONES masked vector grids, lowest zone first.
//
//  Channel   Dir  Fields (low bit up)
//  s_axis    in   tuser: operation; tdata: zone, cell_index, lon_or_west,
//                 lat_or_south, east_edge, north_edge, grid_width,
//                 grid_height, cell_u, cell_v, cell_valid
//  m_axis    out  tuser: found; tdata: wind_u, wind_v, zone_hit
//
// A query tests each zone in turn, dropping it early or carrying it to the
// corner sums: two waits on the shared divider, four serialized corner reads
// of the cell RAM, and nineteen passes through the one shared multiplier,
// before the result is emitted.
// The input is ready only while the sequencer is idle. A result waits in the
// output register; a new query finishing meanwhile holds until it is taken.
// Reset clears only control state; descriptors and cells need a write first.
// ----------------------------------------------------------------------------
module masked_bilinear_field_sampler_core #(
    parameter int NUM_ZONES = 4,
    parameter int MAX_DIM   = 128,
    parameter int MAX_CELLS = 16384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // operation
    input  logic [1:0]                       s_axis_tuser,
    // zone, cell_index, lon_or_west, lat_or_south, east_edge, north_edge,
    // grid_width, grid_height, cell_u, cell_v, cell_valid, zero pad
    input  logic [mbfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // found
    output logic [0:0]                       m_axis_tuser,
    // wind_u, wind_v, zone_hit, zero pad
    output logic [mbfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import mbfs_pkg::*;

    localparam int ZIW   = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam int DEPTH = NUM_ZONES * MAX_CELLS;
    localparam int AW    = $clog2(DEPTH);

    // Input fields
    op_t                in_op;
    logic [1:0]         in_zone;
    logic [13:0]        in_ci;
    logic signed [24:0] in_lon;
    logic signed [23:0] in_lat;
    logic signed [24:0] in_east;
    logic signed [23:0] in_north;
    logic [7:0]         in_gw;
    logic [7:0]         in_gh;
    logic [17:0]        in_u;
    logic [17:0]        in_v;
    logic               in_valid;
    logic               in_fire;
    logic               zone_ok;
    logic [ZIW-1:0]     in_zi;

    assign in_op    = op_t'(s_axis_tuser);
    assign in_zone  = s_axis_tdata[1:0];
    assign in_ci    = s_axis_tdata[15:2];
    assign in_lon   = s_axis_tdata[40:16];
    assign in_lat   = s_axis_tdata[64:41];
    assign in_east  = s_axis_tdata[89:65];
    assign in_north = s_axis_tdata[113:90];
    assign in_gw    = s_axis_tdata[121:114];
    assign in_gh    = s_axis_tdata[129:122];
    assign in_u     = s_axis_tdata[147:130];
    assign in_v     = s_axis_tdata[165:148];
    assign in_valid = s_axis_tdata[166];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign zone_ok  = (32'(in_zone) < NUM_ZONES);
    assign in_zi    = ZIW'(in_zone);

    // Zone descriptors
    logic [NUM_ZONES-1:0] zone_active_reg;
    logic signed [24:0]   west_reg  [NUM_ZONES];
    logic signed [23:0]   south_reg [NUM_ZONES];
    logic signed [24:0]   east_reg  [NUM_ZONES];
    logic signed [23:0]   north_reg [NUM_ZONES];
    logic [7:0]           gw_reg    [NUM_ZONES];
    logic [7:0]           gh_reg    [NUM_ZONES];

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    logic [ZIW-1:0]     zk_reg, zk_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic signed [24:0] lon_reg, lon_next;
    logic signed [23:0] lat_reg, lat_next;
    logic [7:0]         w_reg, w_next;
    logic [7:0]         h_reg, h_next;
    logic signed [25:0] dx_reg, dx_next;
    logic signed [25:0] sx_reg, sx_next;
    logic signed [25:0] dy_reg, dy_next;
    logic signed [25:0] sy_reg, sy_next;
    logic signed [34:0] num_reg, num_next;
    logic [33:0]        lim_reg, lim_next;
    logic [23:0]        px_reg, px_next;
    logic [23:0]        py_reg, py_next;
    logic [15:0]        row0_reg, row0_next;
    logic [15:0]        row1_reg, row1_next;
    logic signed [17:0] cu_reg [4];
    logic signed [17:0] cu_next [4];
    logic signed [17:0] cv_reg [4];
    logic signed [17:0] cv_next [4];
    logic [16:0]        wt_reg [4];
    logic [16:0]        wt_next [4];
    logic signed [37:0] su_reg, su_next;
    logic signed [37:0] sv_reg, sv_next;
    logic               hit_reg, hit_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [17:0]        out_u_reg, out_u_next;
    logic [17:0]        out_v_reg, out_v_next;
    logic [1:0]         out_zone_reg, out_zone_next;
    logic               out_free;

    // Shared multiplier
    logic signed [26:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [44:0] mul_p;

    // Divider hookup
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [DIV_QW-1:0] div_quot;
    logic [DIV_DW-1:0] div_dvs;

    // Cell RAM hookup
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // Derived values
    logic signed [24:0] cur_west, cur_east;
    logic signed [23:0] cur_south, cur_north;
    logic [7:0]         cur_w, cur_h;
    logic [25:0]        sx_abs, sy_abs;
    logic [7:0]         x0, y0, x1, y1;
    logic [8:0]         x0p, y0p;
    logic [15:0]        tx, ty;
    logic [16:0]        wx0, wy0;
    logic [1:0]         corner;
    logic [1:0]         sel;
    logic [16:0]        idx;
    logic               idx_bad;
    logic               zk_last;
    logic               fail;

    assign cur_west  = west_reg[zk_reg];
    assign cur_east  = east_reg[zk_reg];
    assign cur_south = south_reg[zk_reg];
    assign cur_north = north_reg[zk_reg];
    assign cur_w     = gw_reg[zk_reg];
    assign cur_h     = gh_reg[zk_reg];
    assign zk_last   = (32'(zk_reg) == NUM_ZONES - 1);

    assign sx_abs = sx_reg[25] ? $unsigned(-sx_reg) : $unsigned(sx_reg);
    assign sy_abs = sy_reg[25] ? $unsigned(-sy_reg) : $unsigned(sy_reg);

    // Grid cell and fraction; the far corner clamps at the last column/row
    assign x0  = px_reg[23:16];
    assign y0  = py_reg[23:16];
    assign tx  = px_reg[15:0];
    assign ty  = py_reg[15:0];
    assign x0p = {1'b0, x0} + 9'd1;
    assign y0p = {1'b0, y0} + 9'd1;
    assign x1  = (x0p < {1'b0, w_reg}) ? x0p[7:0] : w_reg - 8'd1;
    assign y1  = (y0p < {1'b0, h_reg}) ? y0p[7:0] : h_reg - 8'd1;
    assign wx0 = 17'h10000 - {1'b0, tx};
    assign wy0 = 17'h10000 - {1'b0, ty};

    // Corner index: bit 0 picks the column, bit 1 the row
    assign corner  = cnt_reg[1:0];
    assign sel     = cnt_reg[2:1];
    assign idx     = {1'b0, (corner[1] ? row1_reg : row0_reg)}
                   + {9'd0, (corner[0] ? x1 : x0)};
    assign idx_bad = ({15'd0, idx} >= 32'(MAX_CELLS));

    assign ram_raddr = AW'(zk_reg) * AW'(MAX_CELLS) + AW'(idx);
    assign ram_waddr = AW'(in_zone) * AW'(MAX_CELLS) + AW'(in_ci);
    assign ram_wdata = {in_valid, in_u, in_v};
    assign ram_we    = in_fire && (in_op == OP_LOAD_CELL) && zone_ok
                    && (32'(in_ci) < MAX_CELLS);

    assign mul_p = mul_a * mul_b;

    assign div_dvs = (state_reg == ST_CHKY) ? sy_abs : sx_abs;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // Store descriptors
    always_ff @(posedge clk)
    begin
        if (in_fire && (in_op == OP_LOAD_ZONE) && zone_ok)
        begin
            west_reg[in_zi]  <= in_lon;
            south_reg[in_zi] <= in_lat;
            east_reg[in_zi]  <= in_east;
            north_reg[in_zi] <= in_north;
            gw_reg[in_zi]    <= in_gw;
            gh_reg[in_zi]    <= in_gh;
        end
    end

    // Mark zones active on descriptor loads, drop all on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_active_reg <= '0;
        end
        else if (in_fire && (in_op == OP_CLEAR))
        begin
            zone_active_reg <= '0;
        end
        else if (in_fire && (in_op == OP_LOAD_ZONE) && zone_ok)
        begin
            zone_active_reg[in_zi] <= 1'b1;
        end
    end

    // Sequencer: next state, multiplier operands and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        zk_next        = zk_reg;
        cnt_next       = cnt_reg;
        lon_next       = lon_reg;
        lat_next       = lat_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        dx_next        = dx_reg;
        sx_next        = sx_reg;
        dy_next        = dy_reg;
        sy_next        = sy_reg;
        num_next       = num_reg;
        lim_next       = lim_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        row0_next      = row0_reg;
        row1_next      = row1_reg;
        cu_next        = cu_reg;
        cv_next        = cv_reg;
        wt_next        = wt_reg;
        su_next        = su_reg;
        sv_next        = sv_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_u_next     = out_u_reg;
        out_v_next     = out_v_reg;
        out_zone_next  = out_zone_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        ram_re         = 1'b0;
        fail           = 1'b0;

        // Retire a taken result
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_op == OP_QUERY))
                begin
                    lon_next   = in_lon;
                    lat_next   = in_lat;
                    zk_next    = '0;
                    state_next = ST_ZONE;
                end
            end
            // Skip inactive zones, degenerate boxes and bad dimensions
            ST_ZONE:
            begin
                w_next  = cur_w;
                h_next  = cur_h;
                dx_next = 26'(lon_reg) - 26'(cur_west);
                sx_next = 26'(cur_east) - 26'(cur_west);
                dy_next = 26'(cur_north) - 26'(lat_reg);
                sy_next = 26'(cur_north) - 26'(cur_south);
                if (!zone_active_reg[zk_reg] || (cur_east == cur_west)
                    || (cur_north == cur_south) || (cur_w == 8'd0) || (cur_h == 8'd0)
                    || (32'(cur_w) > MAX_DIM) || (32'(cur_h) > MAX_DIM))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    state_next = ST_AREA;
                end
            end
            ST_AREA:
            begin
                mul_a = 27'($signed({1'b0, w_reg}));
                mul_b = 18'($signed({1'b0, h_reg}));
                if ({15'd0, mul_p[16:0]} > 32'(MAX_CELLS))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    state_next = ST_NUMX;
                end
            end
            // Column numerator, sign folded by the span direction
            ST_NUMX:
            begin
                mul_a      = 27'(sx_reg[25] ? -dx_reg : dx_reg);
                mul_b      = 18'($signed({1'b0, w_reg - 8'd1}));
                num_next   = 35'(mul_p);
                state_next = ST_LIMX;
            end
            ST_LIMX:
            begin
                mul_a      = 27'($signed({1'b0, sx_abs}));
                mul_b      = 18'($signed({1'b0, w_reg - 8'd1}));
                lim_next   = 34'(mul_p);
                state_next = ST_CHKX;
            end
            ST_CHKX:
            begin
                if ((num_reg < 0) || (num_reg > $signed({1'b0, lim_reg})))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAITX;
                end
            end
            ST_WAITX:
            begin
                if (div_done)
                begin
                    px_next    = div_quot;
                    state_next = ST_NUMY;
                end
            end
            // Row numerator, measured down from the north edge
            ST_NUMY:
            begin
                mul_a      = 27'(sy_reg[25] ? -dy_reg : dy_reg);
                mul_b      = 18'($signed({1'b0, h_reg - 8'd1}));
                num_next   = 35'(mul_p);
                state_next = ST_LIMY;
            end
            ST_LIMY:
            begin
                mul_a      = 27'($signed({1'b0, sy_abs}));
                mul_b      = 18'($signed({1'b0, h_reg - 8'd1}));
                lim_next   = 34'(mul_p);
                state_next = ST_CHKY;
            end
            ST_CHKY:
            begin
                if ((num_reg < 0) || (num_reg > $signed({1'b0, lim_reg})))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAITY;
                end
            end
            ST_WAITY:
            begin
                if (div_done)
                begin
                    py_next    = div_quot;
                    state_next = ST_ROW0;
                end
            end
            // Row base offsets
            ST_ROW0:
            begin
                mul_a      = 27'($signed({1'b0, y0}));
                mul_b      = 18'($signed({1'b0, w_reg}));
                row0_next  = 16'(mul_p);
                state_next = ST_ROW1;
            end
            ST_ROW1:
            begin
                mul_a      = 27'($signed({1'b0, y1}));
                mul_b      = 18'($signed({1'b0, w_reg}));
                row1_next  = 16'(mul_p);
                cnt_next   = '0;
                state_next = ST_RADDR;
            end
            // Fetch the four corners, dropping the zone on a masked cell
            ST_RADDR:
            begin
                if (idx_bad)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA:
            begin
                if (!ram_rdata[CELL_W-1])
                begin
                    fail = 1'b1;
                end
                else
                begin
                    cu_next[corner] = ram_rdata[35:18];
                    cv_next[corner] = ram_rdata[17:0];
                    if (corner == 2'd3)
                    begin
                        cnt_next   = '0;
                        state_next = ST_WGT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = ST_RADDR;
                    end
                end
            end
            // Corner weights, truncated to Q1.16
            ST_WGT:
            begin
                mul_a = 27'($signed({1'b0, (corner[0] ? {1'b0, tx} : wx0)}));
                mul_b = $signed({1'b0, (corner[1] ? {1'b0, ty} : wy0)});
                wt_next[corner] = mul_p[32:16];
                if (corner == 2'd3)
                begin
                    cnt_next   = '0;
                    su_next    = '0;
                    sv_next    = '0;
                    state_next = ST_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            // Weighted sums, u on even steps and v on odd ones
            ST_ACC:
            begin
                mul_a = 27'(cnt_reg[0] ? cv_reg[sel] : cu_reg[sel]);
                mul_b = $signed({1'b0, wt_reg[sel]});
                if (cnt_reg[0])
                begin
                    sv_next = sv_reg + 38'(mul_p);
                end
                else
                begin
                    su_next = su_reg + 38'(mul_p);
                end
                if (cnt_reg == 3'd7)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            // Hold until the output register is free
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = hit_reg;
                    out_u_next     = hit_reg ? su_reg[33:16] : 18'd0;
                    out_v_next     = hit_reg ? sv_reg[33:16] : 18'd0;
                    out_zone_next  = hit_reg ? 2'(zk_reg) : 2'd0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance to the next zone, or report not found after the last
        if (fail)
        begin
            if (zk_last)
            begin
                hit_next   = 1'b0;
                state_next = ST_EMIT;
            end
            else
            begin
                zk_next    = zk_reg + 1'b1;
                state_next = ST_ZONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            zk_reg        <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            zk_reg        <= zk_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lon_reg       <= lon_next;
        lat_reg       <= lat_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        dx_reg        <= dx_next;
        sx_reg        <= sx_next;
        dy_reg        <= dy_next;
        sy_reg        <= sy_next;
        num_reg       <= num_next;
        lim_reg       <= lim_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        row0_reg      <= row0_next;
        row1_reg      <= row1_next;
        cu_reg        <= cu_next;
        cv_reg        <= cv_next;
        wt_reg        <= wt_next;
        su_reg        <= su_next;
        sv_reg        <= sv_next;
        out_found_reg <= out_found_next;
        out_u_reg     <= out_u_next;
        out_v_reg     <= out_v_next;
        out_zone_reg  <= out_zone_next;
    end

    mbfs_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .rem_init    (num_reg[33:8]),
        .dividend_lo ({num_reg[7:0], 16'd0}),
        .divisor     (div_dvs),
        .busy        (div_busy),
        .done        (div_done),
        .quot        (div_quot)
    );

    mbfs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {2'd0, out_zone_reg, out_v_reg, out_u_reg};

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_raddr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RADDR && !idx_bad) |-> (32'(ram_raddr) < DEPTH))
        else $error("cell read outside the store");

    a_hit_zone_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && hit_reg) |-> zone_active_reg[zk_reg])
        else $error("result taken from an inactive zone");

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && cnt_reg == 3'd0)
        |-> (({2'd0, wt_reg[0]} + {2'd0, wt_reg[1]} + {2'd0, wt_reg[2]}
              + {2'd0, wt_reg[3]}) <= 19'h10000))
        else $error("corner weights exceed unity");

endmodule

// File: src/mbfs_ram.sv
// ----------------------------------------------------------------------------
// mbfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbfs_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/mbfs_div.sv
// ----------------------------------------------------------------------------
// mbfs_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the high part of the dividend is below the divisor.
// ----------------------------------------------------------------------------
module mbfs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mbfs_pkg::DIV_DW-1:0] rem_init,
    input  logic [mbfs_pkg::DIV_QW-1:0] dividend_lo,
    input  logic [mbfs_pkg::DIV_DW-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [mbfs_pkg::DIV_QW-1:0] quot
);
    import mbfs_pkg::*;

    localparam int CW = $clog2(DIV_QW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_QW-1:0] q_reg, q_next;
    logic [DIV_DW:0]   trial;
    logic              ge;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, q_reg[DIV_QW-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_QW - 1);
            rem_next  = rem_init;
            dvs_next  = divisor;
            q_next    = dividend_lo;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_DW'(trial - {1'b0, dvs_reg}) : DIV_DW'(trial);
            q_next   = {q_reg[DIV_QW-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

endmodule
